>>> design/acpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpr_pkg
// Shared types and constants for the attribute cell pixel renderer.
// ----------------------------------------------------------------------------
package acpr_pkg;

  // Item kinds on the input channel
  localparam logic MODE_CELL = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Pixels per character cell
  localparam int CELL_PIXELS = 8;

  typedef logic [3:0] colour_t;

  // One character cell as taken from the input channel
  typedef struct packed {
    logic [7:0] row;
    logic [4:0] column;
    logic [7:0] bitmap;
    logic [7:0] attr;
  } cell_t;

endpackage

>>> design/acpr_flash_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpr_flash_timer
// Frame tick counter; toggles the flash phase once every FLASH_FRAMES ticks.
// ----------------------------------------------------------------------------
module acpr_flash_timer #(
  parameter int FLASH_FRAMES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic tick,
  output logic flash_phase
);

  localparam int CW = $clog2(FLASH_FRAMES);
  localparam logic [CW-1:0] LAST_COUNT = CW'(FLASH_FRAMES - 1);

  logic [CW-1:0] frame_counter;

  // Counter wraps at the last frame and flips the phase
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= '0;
      flash_phase   <= 1'b0;
    end else if (tick) begin
      if (frame_counter == LAST_COUNT) begin
        frame_counter <= '0;
        flash_phase   <= ~flash_phase;
      end else begin
        frame_counter <= frame_counter + 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_wrap_toggles: assert property (@(posedge clk) disable iff (rst)
    tick && frame_counter == LAST_COUNT |=> frame_counter == '0 &&
      flash_phase != $past(flash_phase))
    else $error("flash phase did not toggle on counter wrap");

  a_phase_holds: assert property (@(posedge clk) disable iff (rst)
    !(tick && frame_counter == LAST_COUNT) |=> $stable(flash_phase))
    else $error("flash phase changed without a counter wrap");
`endif

endmodule

>>> design/acpr_cell_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpr_cell_shifter
// Latches one cell with its resolved ink and paper, then shifts out eight
// pixels, one per transfer, through an output register.
// ----------------------------------------------------------------------------
module acpr_cell_shifter
  import acpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  cell_t      cell_in,
  input  logic       flash_phase,
  output logic       cell_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] pixel_x,
  output logic [7:0] pixel_y,
  output colour_t    colour_index,
  output logic       last
);

  localparam int PW = $clog2(CELL_PIXELS);
  localparam logic [PW-1:0] LAST_PIX = PW'(CELL_PIXELS - 1);

  logic          busy;
  logic [PW-1:0] cnt;
  logic [7:0]    bits;
  colour_t       ink;
  colour_t       paper;
  logic [4:0]    col;
  logic [7:0]    y;

  colour_t ink_next;
  colour_t paper_next;
  logic    emit;
  logic    emit_last;

  // Resolve colours from the attribute, swapping when flashing
  always_comb begin
    ink_next   = {cell_in.attr[6], cell_in.attr[2:0]};
    paper_next = {1'b1, cell_in.attr[5:3]};
    if (cell_in.attr[7] && flash_phase) begin
      ink_next   = {1'b1, cell_in.attr[5:3]};
      paper_next = {1'b1, cell_in.attr[2:0]};
    end
  end

  assign emit       = busy && (!out_valid || out_ready);
  assign emit_last  = emit && (cnt == LAST_PIX);
  assign cell_ready = !busy || emit_last;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (emit) begin
        cnt <= cnt + 1'b1;
        if (emit_last) busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Cell payload and shifter
  always_ff @(posedge clk) begin
    if (load) begin
      bits  <= cell_in.bitmap;
      ink   <= ink_next;
      paper <= paper_next;
      col   <= cell_in.column;
      y     <= cell_in.row;
    end else if (emit) begin
      bits <= {bits[6:0], 1'b0};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x      <= {col, cnt};
      pixel_y      <= y;
      colour_index <= bits[7] ? ink : paper;
      last         <= (cnt == LAST_PIX);
    end
  end

`ifndef ASSERT_OFF
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && cnt == '0)
    else $error("cell load did not start a pixel run");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> pixel_x[PW-1:0] == LAST_PIX)
    else $error("last flag on wrong pixel position");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    emit_last && !load |=> !busy)
    else $error("shifter stayed busy after eighth pixel");
`endif

endmodule

>>> design/attribute_cell_pixel_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attribute_cell_pixel_renderer
// Character-cell renderer: one cell in, eight attribute-coloured pixels out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries either a cell (mode 0: row,
//   column, bitmap_byte, attribute_byte) or a frame tick (mode 1, payload
//   ignored). Output channel (out_valid/out_ready) carries one pixel per
//   transfer, leftmost first, with last set on the eighth pixel.
//   The first pixel of a cell passes through the cell payload register and
//   then the output register. Throughput: one pixel per cycle while the
//   receiver does not stall; the next item is taken in the cycle the eighth
//   pixel moves to the output register, so cells stream back to back. Ticks
//   share the input channel and are taken under the same ready.
//   Flash phase is sampled when a cell is taken, so ticks that follow it
//   never affect its pixels.
//   Reset (rst, synchronous) clears the frame counter, flash phase, busy
//   flag and out_valid. When the receiver stalls, the output register
//   holds its pixel and the shifter and input channel stall behind it.
// ----------------------------------------------------------------------------
module attribute_cell_pixel_renderer
  import acpr_pkg::*;
#(
  parameter int FLASH_FRAMES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [7:0] row,
  input  logic [4:0] column,
  input  logic [7:0] bitmap_byte,
  input  logic [7:0] attribute_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] pixel_x,
  output logic [7:0] pixel_y,
  output logic [3:0] colour_index,
  output logic       last
);

  logic  xfer;
  logic  tick;
  logic  load;
  logic  flash_phase;
  logic  cell_ready;
  cell_t cell_in;

  // Input transfer decode
  assign xfer     = in_valid && in_ready;
  assign tick     = xfer && (mode == MODE_TICK);
  assign load     = xfer && (mode == MODE_CELL);
  assign in_ready = cell_ready;
  assign cell_in  = '{row: row, column: column, bitmap: bitmap_byte,
                      attr: attribute_byte};

  acpr_flash_timer #(
    .FLASH_FRAMES(FLASH_FRAMES)
  ) u_timer (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .flash_phase (flash_phase)
  );

  acpr_cell_shifter u_shifter (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .cell_in      (cell_in),
    .flash_phase  (flash_phase),
    .cell_ready   (cell_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .colour_index (colour_index),
    .last         (last)
  );

endmodule

>>> dv/acpr_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpr_pixel_checker
// Watches both channels of the cell renderer, predicts each cell's eight
// pixels from its own frame counter and flash phase, and compares every
// output transfer against the oldest pending pixel.
// ----------------------------------------------------------------------------
module acpr_pixel_checker
  import acpr_pkg::*;
#(
  parameter int FLASH_FRAMES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       mode,
  input  logic [7:0] row,
  input  logic [4:0] column,
  input  logic [7:0] bitmap_byte,
  input  logic [7:0] attribute_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] pixel_x,
  input  logic [7:0] pixel_y,
  input  logic [3:0] colour_index,
  input  logic       last,
  output int         pending,
  output int         errors
);

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    colour_t    colour;
    logic       last;
  } pixel_t;

  pixel_t expected_pixels[$];
  int     tick_count;
  logic   flash_on;

  // Count and print one mismatch; printing stops after a while
  task automatic report(string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Expand one cell into its eight pixels, leftmost first
  task automatic render_cell(cell_t c, logic flash_phase);
    colour_t ink;
    colour_t paper;
    colour_t swap;
    pixel_t  p;
    ink   = {c.attr[6], c.attr[2:0]};
    paper = {1'b1, c.attr[5:3]};
    if (c.attr[7] && flash_phase) begin
      swap  = ink;
      ink   = paper;
      paper = swap | 4'h8;
    end
    for (int q = 0; q < CELL_PIXELS; q++) begin
      p.x      = {c.column, 3'(q)};
      p.y      = c.row;
      p.colour = c.bitmap[7 - q] ? ink : paper;
      p.last   = (q == CELL_PIXELS - 1);
      expected_pixels.push_back(p);
    end
  endtask

  always @(posedge clk) begin : watch
    pixel_t want;
    if (rst) begin
      tick_count = 0;
      flash_on   = 1'b0;
      expected_pixels.delete();
    end else begin
      // input transfer: frame tick or cell
      if (in_valid && in_ready) begin
        if (mode == MODE_TICK) begin
          tick_count++;
          if (tick_count >= FLASH_FRAMES) begin
            tick_count = 0;
            flash_on   = !flash_on;
          end
        end else begin
          render_cell('{row: row, column: column, bitmap: bitmap_byte,
                        attr: attribute_byte}, flash_on);
        end
      end
      // output transfer: compare with the oldest pixel
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report($sformatf("unexpected pixel x=%0d y=%0d colour=%0d last=%0b",
                           pixel_x, pixel_y, colour_index, last));
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_x !== want.x)
            report($sformatf("pixel_x got %0d, expected %0d", pixel_x, want.x));
          if (pixel_y !== want.y)
            report($sformatf("pixel_y got %0d, expected %0d (x=%0d)",
                             pixel_y, want.y, want.x));
          if (colour_index !== want.colour)
            report($sformatf("colour_index got %0d, expected %0d (x=%0d y=%0d)",
                             colour_index, want.colour, want.x, want.y));
          if (last !== want.last)
            report($sformatf("last got %b, expected %b (x=%0d y=%0d)",
                             last, want.last, want.x, want.y));
        end
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the attribute cell pixel renderer. A directed
// pass covers field extremes, ticks through a flash toggle and flashing
// cells; random cells and ticks then run under four idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import acpr_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 19;
  localparam int DRAIN_CYCLES = 16;

  logic       clk;
  logic       rst            = 1'b1;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic       mode           = MODE_CELL;
  logic [7:0] row            = '0;
  logic [4:0] column         = '0;
  logic [7:0] bitmap_byte    = '0;
  logic [7:0] attribute_byte = '0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [3:0] colour_index;
  logic       last;

  int pending;
  int errors;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  int send_pct_by_phase[4] = '{0, 74, 0, 28};
  int recv_pct_by_phase[4] = '{0, 0, 74, 28};

  attribute_cell_pixel_renderer dut (
    .clk, .rst, .in_valid, .in_ready, .mode, .row, .column, .bitmap_byte,
    .attribute_byte, .out_valid, .out_ready, .pixel_x, .pixel_y,
    .colour_index, .last
  );

  acpr_pixel_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .mode, .row, .column, .bitmap_byte,
    .attribute_byte, .out_valid, .out_ready, .pixel_x, .pixel_y,
    .colour_index, .last, .pending, .errors
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One input transfer, after an optional random gap
  task automatic send_item(logic kind, logic [7:0] r, logic [4:0] c,
                           logic [7:0] b, logic [7:0] a);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    mode           <= kind;
    row            <= r;
    column         <= c;
    bitmap_byte    <= b;
    attribute_byte <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every pending pixel has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    logic [7:0] r;
    if ($urandom_range(0, 99) < 30) begin
      send_item(MODE_TICK, 8'($urandom), 5'($urandom), 8'($urandom),
                8'($urandom));
    end else begin
      // mostly on-screen rows, now and then the full byte
      r = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 191));
      send_item(MODE_CELL, r, 5'($urandom_range(0, 31)), 8'($urandom),
                8'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes with flash phase off
    send_item(MODE_CELL, 8'd0,   5'd0,  8'h00, 8'h00);
    send_item(MODE_CELL, 8'd191, 5'd31, 8'hFF, 8'hFF);
    send_item(MODE_CELL, 8'd255, 5'd31, 8'hA5, 8'h47);
    send_item(MODE_CELL, 8'd128, 5'd16, 8'h5A, 8'h38);
    send_item(MODE_CELL, 8'd1,   5'd1,  8'h80, 8'h7F);
    send_item(MODE_CELL, 8'd64,  5'd10, 8'h01, 8'h80);
    // a full frame count of ticks turns the flash phase on; payload ignored
    for (int i = 0; i < 16; i++)
      send_item(MODE_TICK, 8'hFF, 5'h1F, 8'hFF, 8'hFF);
    // flashing cells swap ink and paper, non-flashing ones do not
    send_item(MODE_CELL, 8'd100, 5'd5,  8'hF0, 8'hFF);
    send_item(MODE_CELL, 8'd2,   5'd30, 8'h0F, 8'h87);
    send_item(MODE_CELL, 8'd190, 5'd7,  8'hCC, 8'h47);

    // random cells and ticks under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      send_idle_pct  = send_pct_by_phase[ph];
      recv_stall_pct = recv_pct_by_phase[ph];
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random_item();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
